>>> design/ptt_pkg.sv
// Shared types and constants of the periodic task timer table.
`timescale 1ns / 1ps

package ptt_pkg;

    localparam int ID_W     = 8;
    localparam int TIME_W   = 24;
    localparam int LIFE_W   = 16;
    localparam int TOTAL_W  = 32;
    localparam int PRES_W   = 5;

    localparam logic [TIME_W-1:0] MIN_MS = TIME_W'(10);

    localparam int DEF_NUM_TASKS = 16;
    localparam int DEF_TICK_MS   = 10;

    typedef enum logic [2:0] {
        K_TICK      = 3'd0,
        K_CREATE    = 3'd1,
        K_SET_TIMES = 3'd2,
        K_RELOAD    = 3'd3,
        K_SET_STATE = 3'd4,
        K_SET_LIFE  = 3'd5,
        K_DISPATCH  = 3'd6,
        K_QUERY     = 3'd7
    } t_kind;

    // command word
    typedef struct packed {
        t_kind              kind;
        logic [ID_W-1:0]    task_id;
        logic [TIME_W-1:0]  time_ms;
        logic [TIME_W-1:0]  period_ms;
        logic               run_enable;
        logic [LIFE_W-1:0]  runs_left;
        logic               notify_on_expire;
    } t_cmd;

    // result word
    typedef struct packed {
        logic [ID_W-1:0]    out_task_id;
        logic               fired;
        logic               expired;
        logic [TIME_W-1:0]  interval_ms;
        logic [TIME_W-1:0]  remaining;
        logic               found;
        logic [TOTAL_W-1:0] tick_total;
        logic [PRES_W-1:0]  tasks_present;
        logic               last;
    } t_res;

    // operation handed from cell to cell, times already in ticks
    typedef struct packed {
        logic               valid;
        t_kind              kind;
        logic [ID_W-1:0]    id;
        logic [TIME_W-1:0]  t0;
        logic [TIME_W-1:0]  t1;
        logic               run_enable;
        logic [LIFE_W-1:0]  runs_left;
        logic               notify;
    } t_word;

    // what a cell reports in the cycle it acts
    typedef struct packed {
        logic               hit;
        logic               found;
        logic [TIME_W-1:0]  remaining;
        logic               fire;
        logic               expired;
        logic               freed;
        logic               added;
        logic [TIME_W-1:0]  period;
    } t_evt;

endpackage

>>> design/ptt_cmd_if.sv
// Command channel: valid/ready handshake carrying one command word.
`timescale 1ns / 1ps

interface ptt_cmd_if
    import ptt_pkg::*;
();
    logic valid;
    logic ready;
    t_cmd payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

>>> design/ptt_res_if.sv
// Result channel: valid/ready handshake carrying one result word.
`timescale 1ns / 1ps

interface ptt_res_if
    import ptt_pkg::*;
();
    logic valid;
    logic ready;
    t_res payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

>>> design/ptt_cell.sv
// One task slot of the timer chain; applies the passing operation and forwards it.
`timescale 1ns / 1ps

module ptt_cell
    import ptt_pkg::*;
#(
    parameter int IDX = 0
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_adv,
    input  t_word i_word,
    output t_word o_word,
    output t_evt  o_evt
);

    logic               r_used, n_used;
    logic [TIME_W-1:0]  r_cd, n_cd;
    logic [TIME_W-1:0]  r_per, n_per;
    logic               r_ready, n_ready;
    logic               r_run, n_run;
    logic [LIFE_W-1:0]  r_life, n_life;
    logic               r_notify, n_notify;
    t_word              r_word;

    logic act, hit;

    assign act = i_adv && i_word.valid;
    assign hit = (i_word.id == ID_W'(IDX));

    always_comb begin
        n_used   = r_used;
        n_cd     = r_cd;
        n_per    = r_per;
        n_ready  = r_ready;
        n_run    = r_run;
        n_life   = r_life;
        n_notify = r_notify;
        o_evt    = '0;
        if (act) begin
            unique case (i_word.kind)
                K_TICK: begin
                    if (r_used) begin
                        if (r_cd <= TIME_W'(1)) begin
                            n_cd    = r_per;
                            n_ready = 1'b1;
                        end else begin
                            n_cd = r_cd - TIME_W'(1);
                        end
                    end
                end
                K_CREATE: begin
                    if (hit) begin
                        o_evt.added = !r_used;
                        n_used   = 1'b1;
                        n_cd     = i_word.t0;
                        n_per    = i_word.t0;
                        n_ready  = 1'b0;
                        n_run    = 1'b1;
                        n_life   = '0;
                        n_notify = 1'b0;
                    end
                end
                K_SET_TIMES: begin
                    if (hit && r_used) begin
                        n_cd  = i_word.t0;
                        n_per = i_word.t1;
                    end
                end
                K_RELOAD: begin
                    if (hit && r_used) n_cd = r_per;
                end
                K_SET_STATE: begin
                    if (hit && r_used) n_run = i_word.run_enable;
                end
                K_SET_LIFE: begin
                    if (hit && r_used) begin
                        n_life   = i_word.runs_left;
                        n_notify = i_word.notify;
                    end
                end
                K_DISPATCH: begin
                    if (r_used && r_run && r_ready) begin
                        o_evt.fire   = 1'b1;
                        o_evt.period = r_per;
                        n_ready      = 1'b0;
                        if (r_life != '0) begin
                            n_life = r_life - LIFE_W'(1);
                            if (r_life == LIFE_W'(1)) begin
                                // last run: slot is freed
                                o_evt.freed   = 1'b1;
                                o_evt.expired = r_notify;
                                n_used   = 1'b0;
                                n_cd     = '0;
                                n_per    = '0;
                                n_run    = 1'b0;
                                n_life   = '0;
                                n_notify = 1'b0;
                            end
                        end
                    end
                end
                K_QUERY: begin
                end
                default: begin
                end
            endcase
            if (hit && i_word.kind != K_TICK && i_word.kind != K_DISPATCH) begin
                o_evt.hit       = 1'b1;
                o_evt.found     = n_used;
                o_evt.remaining = (i_word.kind == K_QUERY && r_used) ? r_cd : '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used       <= 1'b0;
            r_cd         <= '0;
            r_per        <= '0;
            r_ready      <= 1'b0;
            r_run        <= 1'b0;
            r_life       <= '0;
            r_notify     <= 1'b0;
            r_word.valid <= 1'b0;
        end else begin
            r_used   <= n_used;
            r_cd     <= n_cd;
            r_per    <= n_per;
            r_ready  <= n_ready;
            r_run    <= n_run;
            r_life   <= n_life;
            r_notify <= n_notify;
            if (i_adv) r_word.valid <= i_word.valid;
        end
        if (i_adv) begin
            r_word.kind       <= i_word.kind;
            r_word.id         <= i_word.id;
            r_word.t0         <= i_word.t0;
            r_word.t1         <= i_word.t1;
            r_word.run_enable <= i_word.run_enable;
            r_word.runs_left  <= i_word.runs_left;
            r_word.notify     <= i_word.notify;
        end
    end

    assign o_word = r_word;

endmodule

>>> design/periodic_task_timer_table_top.sv
// Top level of the periodic task timer table: command decode, cell chain, result register.
`timescale 1ns / 1ps

// Usage:
//   i_cmd takes one command word (tick, create, set times, reload, set state,
//   set life, dispatch, query). o_res returns the result words of it; the
//   final word of every command carries last = 1.
//   Each command walks the row of NUM_TASKS slot cells, one cell per cycle
//   while the result register can take a word. After accept the command is
//   converted, then launched into cell 0; the final result word is registered
//   as the command leaves the last cell, and i_cmd is ready again from there, so
//   the rate of commands is set by the walk along the cell chain. A dispatch
//   shows its fired words while the walk passes the ready slots, in slot order.
//   Times in ms are clamped to a minimum of 10 ms and divided by TICK_MS
//   through a reciprocal multiply that is registered in S_CONV after accept.
//   When o_res stalls, the whole chain freezes with the command in place, so
//   no result word is dropped; i_cmd stays not ready until the command is done.
//   Reset (i_rst_n low, synchronous) empties every slot and clears the tick
//   and occupancy counts; the block is ready in the first cycle after reset.
module periodic_task_timer_table_top
    import ptt_pkg::*;
#(
    parameter int NUM_TASKS = DEF_NUM_TASKS,
    parameter int TICK_MS   = DEF_TICK_MS
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    ptt_cmd_if.sink       i_cmd,
    ptt_res_if.source     o_res
);

    localparam int CNT_W  = $clog2(NUM_TASKS + 1);
    // exact floor division by TICK_MS via multiply and shift
    localparam int SH     = TIME_W + $clog2(TICK_MS);
    localparam int MUL_W  = TIME_W + 1;
    localparam int PROD_W = TIME_W + MUL_W;
    localparam logic [63:0] MUL64 =
        ((64'd1 << SH) + 64'(TICK_MS) - 64'd1) / 64'(TICK_MS);
    localparam logic [MUL_W-1:0] MUL = MUL_W'(MUL64);
    localparam int TK_W = $clog2(TICK_MS + 1);
    localparam logic [TK_W-1:0] TK = TK_W'(TICK_MS);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CONV,
        S_LAUNCH,
        S_WALK
    } t_state;

    t_state               r_state;
    t_cmd                 r_cmd;
    logic [PROD_W-1:0]    r_prod0, r_prod1;
    logic [TOTAL_W-1:0]   r_ticks;
    logic [CNT_W-1:0]     r_count, n_count;
    logic                 r_found;
    logic [TIME_W-1:0]    r_rem;
    logic                 r_out_valid, n_out_valid;
    t_res                 r_out;

    logic [TIME_W-1:0]    c0, c1;
    logic [PROD_W-1:0]    p0, p1;
    logic                 adv;
    logic                 close_now;
    logic [ID_W-1:0]      fire_id;
    t_word                w [NUM_TASKS+1];
    t_evt                 evt [NUM_TASKS];
    t_evt                 evt_all;
    logic [NUM_TASKS-1:0] busy_vec;
    logic [NUM_TASKS-1:0] hit_vec;
    logic [TIME_W+TK_W-1:0] ival;

    // ms to ticks
    assign c0 = (r_cmd.time_ms < MIN_MS)   ? MIN_MS : r_cmd.time_ms;
    assign c1 = (r_cmd.period_ms < MIN_MS) ? MIN_MS : r_cmd.period_ms;
    assign p0 = c0 * MUL;
    assign p1 = c1 * MUL;

    // chain only moves while the result register can take a word
    assign adv = !r_out_valid || o_res.ready;

    // command leaves the last cell: closing word goes out
    assign close_now = (r_state == S_WALK) && adv && w[NUM_TASKS].valid;

    always_comb begin
        w[0].valid      = (r_state == S_LAUNCH);
        w[0].kind       = r_cmd.kind;
        w[0].id         = r_cmd.task_id;
        w[0].t0         = TIME_W'(r_prod0 >> SH);
        w[0].t1         = TIME_W'(r_prod1 >> SH);
        w[0].run_enable = r_cmd.run_enable;
        w[0].runs_left  = r_cmd.runs_left;
        w[0].notify     = r_cmd.notify_on_expire;
    end

    for (genvar g = 0; g < NUM_TASKS; g++) begin : g_cell
        ptt_cell #(
            .IDX (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (adv),
            .i_word  (w[g]),
            .o_word  (w[g+1]),
            .o_evt   (evt[g])
        );
        assign busy_vec[g] = w[g+1].valid;
        assign hit_vec[g]  = evt[g].hit;
    end

    // only the cell holding the command reports, so OR merges them
    always_comb begin
        evt_all = '0;
        for (int i = 0; i < NUM_TASKS; i++) evt_all = evt_all | evt[i];
    end

    always_comb begin
        fire_id = '0;
        for (int i = 0; i < NUM_TASKS; i++) begin
            if (evt[i].fire) fire_id = ID_W'(i);
        end
    end

    always_comb begin
        n_count = r_count;
        if (evt_all.added) n_count = r_count + CNT_W'(1);
        if (evt_all.freed) n_count = r_count - CNT_W'(1);
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (adv) n_out_valid = 1'b0;
        if (close_now || evt_all.fire) n_out_valid = 1'b1;
    end

    assign ival = evt_all.period * TK;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ticks     <= '0;
            r_count     <= '0;
            r_found     <= 1'b0;
            r_rem       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
            unique case (r_state)
                S_IDLE: begin
                    if (i_cmd.valid) r_state <= S_CONV;
                end
                S_CONV: begin
                    r_state <= S_LAUNCH;
                end
                S_LAUNCH: begin
                    if (adv) begin
                        r_state <= S_WALK;
                        r_found <= evt_all.hit && evt_all.found;
                        r_rem   <= evt_all.hit ? evt_all.remaining : '0;
                        if (r_cmd.kind == K_TICK && r_count != '0) begin
                            r_ticks <= r_ticks + TOTAL_W'(1);
                        end
                    end
                end
                S_WALK: begin
                    if (evt_all.hit) begin
                        r_found <= evt_all.found;
                        r_rem   <= evt_all.remaining;
                    end
                    if (close_now) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end

        if (r_state == S_IDLE && i_cmd.valid) r_cmd <= i_cmd.payload;
        if (r_state == S_CONV) begin
            r_prod0 <= p0;
            r_prod1 <= p1;
        end

        // result payload
        if (evt_all.fire) begin
            r_out.out_task_id   <= fire_id;
            r_out.fired         <= 1'b1;
            r_out.expired       <= evt_all.expired;
            r_out.interval_ms   <= TIME_W'(ival);
            r_out.remaining     <= '0;
            r_out.found         <= 1'b1;
            r_out.tick_total    <= r_ticks;
            r_out.tasks_present <= PRES_W'(n_count);
            r_out.last          <= 1'b0;
        end else if (close_now) begin
            // closing word of the command
            r_out.out_task_id   <= (r_cmd.kind == K_DISPATCH) ? '0 : r_cmd.task_id;
            r_out.fired         <= 1'b0;
            r_out.expired       <= 1'b0;
            r_out.interval_ms   <= '0;
            r_out.remaining     <= r_rem;
            r_out.found         <= r_found;
            r_out.tick_total    <= r_ticks;
            r_out.tasks_present <= PRES_W'(r_count);
            r_out.last          <= 1'b1;
        end
    end

    assign i_cmd.ready   = (r_state == S_IDLE);
    assign o_res.valid   = r_out_valid;
    assign o_res.payload = r_out;

    // the command sits in one cell at a time
    a_one_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(busy_vec))
        else $error("command held in more than one cell");

    a_one_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(hit_vec))
        else $error("more than one cell claims the addressed slot");

    a_idle_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.ready |-> (busy_vec == '0))
        else $error("new command taken while chain is busy");

    a_fired_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.payload.fired) |-> !o_res.payload.last)
        else $error("fired word marked last");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(NUM_TASKS))
        else $error("occupancy above table size");

endmodule
